// File: rtl/lpsd_pkg.sv
`timescale 1ns / 1ps

package lpsd_pkg;

   typedef enum logic [2:0] {
      PH_HASH = 3'd0,
      PH_HDIG = 3'd1,
      PH_PAY  = 3'd2,
      PH_AT   = 3'd3,
      PH_TDIG = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_END   = 2'd1,
      KIND_FINAL = 2'd2,
      KIND_TRUNC = 2'd3
   } kind_type;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [2:0] PREFIX_LEN = 3'd4;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [15:0] record_length;
      logic        delimiter_error;
      logic        length_overflow;
      logic        length_mismatch;
      logic        trailer_prefix_bad;
      logic        checksum_mismatch;
      logic [31:0] expected_sum;
   } rsp_type;

   // characters of the "sum=" trailer prefix
   function automatic logic [7:0] prefix_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h73;
         2'd1:    c = 8'h75;
         2'd2:    c = 8'h6d;
         default: c = 8'h3d;
      endcase
      return c;
   endfunction

endpackage

// File: rtl/length_prefixed_string_deframer_core.sv
`timescale 1ns / 1ps

// Deframer for a byte stream of records '#' length ':' payload '@' length '*'.
// One byte beat is taken per cycle with no gaps while req_stall is low: each
// accepted byte updates the registered parse state, and its result (a payload
// byte, a record end, a final record end with the "sum=" trailer check, or a
// truncation notice) is shown from the output register, via the skid register
// behind it when the output is held, so input goes on while a result is held;
// req_stall rises only once both are full. Lengths saturate at 2^LEN_BITS-1
// and the running sum and trailer value at 2^SUM_BITS-1. After a final or
// truncation result the parser is back in its reset state for the next stream.
module length_prefixed_string_deframer_core #(
   parameter int LEN_BITS = 16,
   parameter int SUM_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_is_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [7:0]  rsp_data_byte,
   output logic [15:0] rsp_record_length,
   output logic        rsp_delimiter_error,
   output logic        rsp_length_overflow,
   output logic        rsp_length_mismatch,
   output logic        rsp_trailer_prefix_bad,
   output logic        rsp_checksum_mismatch,
   output logic [31:0] rsp_expected_sum
);
   import lpsd_pkg::*;

   localparam int LW = LEN_BITS + 4;
   localparam int SW = SUM_BITS + 4;
   localparam int AW = ((LEN_BITS > SUM_BITS) ? LEN_BITS : SUM_BITS) + 1;

   localparam logic [LEN_BITS-1:0] LEN_MAX = '1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   phase_type           phase_ff, phase_in;
   logic [LEN_BITS-1:0] header_length_ff, header_length_in;
   logic [LEN_BITS-1:0] payload_left_ff, payload_left_in;
   logic [LEN_BITS-1:0] trailer_length_ff, trailer_length_in;
   logic                flag_delim_ff, flag_delim_in;
   logic                flag_ovf_ff, flag_ovf_in;
   logic [SUM_BITS-1:0] sum_before_ff, sum_before_in;
   logic [2:0]          prefix_matched_ff, prefix_matched_in;
   logic [SUM_BITS-1:0] trailer_value_ff, trailer_value_in;
   logic                digits_done_ff, digits_done_in;

   rsp_type out_ff, skid_ff, new_rsp;
   logic    out_valid_ff, skid_valid_ff;
   logic    accept, has_rsp, closed;

   logic                is_digit;
   logic [3:0]          digit;
   logic [LW-1:0]       hdr_wide, tlen_wide;
   logic [SW-1:0]       tval_wide;
   logic [LEN_BITS-1:0] hdr_next, tlen_next;
   logic [SUM_BITS-1:0] tval_next, sum_next;
   logic                hdr_sat, tlen_sat;
   logic [AW-1:0]       sum_wide;
   logic [SUM_BITS-1:0] check_value;
   logic [LEN_BITS+15:0] len_ext;
   logic [SUM_BITS+31:0] sum_ext;

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign is_digit = req_in_byte inside {[CH_ZERO:CH_NINE]};
   assign digit    = is_digit ? 4'(req_in_byte - CH_ZERO) : 4'd0;

   // v*10 + d with room to spot saturation
   assign hdr_wide  = (LW'(header_length_ff) << 3) + (LW'(header_length_ff) << 1) + LW'(digit);
   assign tlen_wide = (LW'(trailer_length_ff) << 3) + (LW'(trailer_length_ff) << 1)
                      + LW'(digit);
   assign tval_wide = (SW'(trailer_value_ff) << 3) + (SW'(trailer_value_ff) << 1)
                      + SW'(digit);
   assign hdr_sat   = |hdr_wide[LW-1:LEN_BITS];
   assign tlen_sat  = |tlen_wide[LW-1:LEN_BITS];
   assign hdr_next  = hdr_sat ? LEN_MAX : hdr_wide[LEN_BITS-1:0];
   assign tlen_next = tlen_sat ? LEN_MAX : tlen_wide[LEN_BITS-1:0];
   assign tval_next = (|tval_wide[SW-1:SUM_BITS]) ? SUM_MAX : tval_wide[SUM_BITS-1:0];

   assign sum_wide = AW'(sum_before_ff) + AW'(header_length_ff);
   assign sum_next = (sum_wide > AW'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_BITS-1:0];

   assign check_value = (prefix_matched_ff < PREFIX_LEN) ? '0 : trailer_value_ff;
   assign len_ext     = {16'b0, header_length_ff};
   assign sum_ext     = {32'b0, sum_before_ff};

   always_comb begin
      phase_in          = phase_ff;
      header_length_in  = header_length_ff;
      payload_left_in   = payload_left_ff;
      trailer_length_in = trailer_length_ff;
      flag_delim_in     = flag_delim_ff;
      flag_ovf_in       = flag_ovf_ff;
      sum_before_in     = sum_before_ff;
      prefix_matched_in = prefix_matched_ff;
      trailer_value_in  = trailer_value_ff;
      digits_done_in    = digits_done_ff;
      new_rsp           = '0;
      has_rsp           = 1'b0;
      closed            = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_HDIG: begin
               if (is_digit) begin
                  header_length_in = hdr_next;
                  if (hdr_sat) flag_ovf_in = 1'b1;
               end else begin
                  if (req_in_byte != CH_COLON) flag_delim_in = 1'b1;
                  payload_left_in = header_length_ff;
                  phase_in = (header_length_ff != '0) ? PH_PAY : PH_AT;
               end
            end
            PH_PAY: begin
               if (!digits_done_ff) begin
                  if (prefix_matched_ff < PREFIX_LEN) begin
                     if (req_in_byte == prefix_char(prefix_matched_ff[1:0]))
                        prefix_matched_in = prefix_matched_ff + 3'd1;
                     else
                        digits_done_in = 1'b1;
                  end else if (is_digit) begin
                     trailer_value_in = tval_next;
                  end else begin
                     digits_done_in = 1'b1;
                  end
               end
               payload_left_in = payload_left_ff - LEN_BITS'(1);
               if (payload_left_ff == LEN_BITS'(1)) phase_in = PH_AT;
               new_rsp.kind      = KIND_DATA;
               new_rsp.data_byte = req_in_byte;
               has_rsp           = 1'b1;
            end
            PH_AT: begin
               if (req_in_byte != CH_AT) flag_delim_in = 1'b1;
               phase_in = PH_TDIG;
            end
            PH_TDIG: begin
               if (is_digit) begin
                  trailer_length_in = tlen_next;
                  if (tlen_sat) flag_ovf_in = 1'b1;
               end else begin
                  closed                  = 1'b1;
                  has_rsp                 = 1'b1;
                  new_rsp.record_length   = len_ext[15:0];
                  new_rsp.delimiter_error = flag_delim_ff || (req_in_byte != CH_STAR);
                  new_rsp.length_overflow = flag_ovf_ff;
                  new_rsp.length_mismatch = header_length_ff != trailer_length_ff;
                  new_rsp.expected_sum    = sum_ext[31:0];
                  if (req_is_last) begin
                     new_rsp.kind               = KIND_FINAL;
                     new_rsp.trailer_prefix_bad = prefix_matched_ff < PREFIX_LEN;
                     new_rsp.checksum_mismatch  = check_value != sum_before_ff;
                     phase_in          = PH_HASH;
                     header_length_in  = '0;
                     payload_left_in   = '0;
                     trailer_length_in = '0;
                     flag_delim_in     = 1'b0;
                     flag_ovf_in       = 1'b0;
                     sum_before_in     = '0;
                     prefix_matched_in = '0;
                     trailer_value_in  = '0;
                     digits_done_in    = 1'b0;
                  end else begin
                     new_rsp.kind  = KIND_END;
                     sum_before_in = sum_next;
                     phase_in      = PH_HASH;
                  end
               end
            end
            default: begin
               header_length_in  = '0;
               payload_left_in   = '0;
               trailer_length_in = '0;
               flag_delim_in     = req_in_byte != CH_HASH;
               flag_ovf_in       = 1'b0;
               prefix_matched_in = '0;
               trailer_value_in  = '0;
               digits_done_in    = 1'b0;
               phase_in          = PH_HDIG;
            end
         endcase

         // last beat anywhere but a closing slot ends the stream as truncated
         if (req_is_last && !closed) begin
            new_rsp           = '0;
            new_rsp.kind      = KIND_TRUNC;
            has_rsp           = 1'b1;
            phase_in          = PH_HASH;
            header_length_in  = '0;
            payload_left_in   = '0;
            trailer_length_in = '0;
            flag_delim_in     = 1'b0;
            flag_ovf_in       = 1'b0;
            sum_before_in     = '0;
            prefix_matched_in = '0;
            trailer_value_in  = '0;
            digits_done_in    = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_HASH;
         header_length_ff  <= '0;
         payload_left_ff   <= '0;
         trailer_length_ff <= '0;
         flag_delim_ff     <= 1'b0;
         flag_ovf_ff       <= 1'b0;
         sum_before_ff     <= '0;
         prefix_matched_ff <= '0;
         trailer_value_ff  <= '0;
         digits_done_ff    <= 1'b0;
      end else begin
         phase_ff          <= phase_in;
         header_length_ff  <= header_length_in;
         payload_left_ff   <= payload_left_in;
         trailer_length_ff <= trailer_length_in;
         flag_delim_ff     <= flag_delim_in;
         flag_ovf_ff       <= flag_ovf_in;
         sum_before_ff     <= sum_before_in;
         prefix_matched_ff <= prefix_matched_in;
         trailer_value_ff  <= trailer_value_in;
         digits_done_ff    <= digits_done_in;
      end
   end

   // output register with a skid register behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= has_rsp;
         end
      end else if (has_rsp) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) out_ff <= skid_ff;
         else if (has_rsp)  out_ff <= new_rsp;
      end else if (has_rsp) begin
         skid_ff <= new_rsp;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_result_kind        = out_ff.kind;
   assign rsp_data_byte          = out_ff.data_byte;
   assign rsp_record_length      = out_ff.record_length;
   assign rsp_delimiter_error    = out_ff.delimiter_error;
   assign rsp_length_overflow    = out_ff.length_overflow;
   assign rsp_length_mismatch    = out_ff.length_mismatch;
   assign rsp_trailer_prefix_bad = out_ff.trailer_prefix_bad;
   assign rsp_checksum_mismatch  = out_ff.checksum_mismatch;
   assign rsp_expected_sum       = out_ff.expected_sum;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds a beat while output register is empty");

   a_stream_end_resets: assert property (@(posedge clock) disable iff (reset)
      (has_rsp && (new_rsp.kind == KIND_FINAL || new_rsp.kind == KIND_TRUNC))
      |=> (phase_ff == PH_HASH && sum_before_ff == '0))
      else $error("parser not back at reset state after stream end");

   a_payload_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAY) |-> (payload_left_ff != '0))
      else $error("payload phase with no bytes left");

endmodule

// File: tb/sv/tb_length_prefixed_string_deframer_core.sv
`timescale 1ns / 1ps

module tb_length_prefixed_string_deframer_core;
   import lpsd_pkg::*;

   localparam int          CYCLE_LIMIT = 500000;
   localparam int          HOLD_CYCLES = 200;
   localparam logic [31:0] LEN_TOP     = 32'h0000_FFFF;
   localparam logic [31:0] SUM_TOP     = 32'hFFFF_FFFF;
   localparam logic [31:0] SUM_TAG     = "sum=";

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_type;
   typedef enum int {TRL_MATCH, TRL_OTHER, TRL_HUGE} trl_mode_type;
   typedef enum int {SLOT_NONE, SLOT_HASH, SLOT_COLON, SLOT_AT, SLOT_STAR} slot_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_is_last;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [7:0]  rsp_data_byte;
   logic [15:0] rsp_record_length;
   logic        rsp_delimiter_error;
   logic        rsp_length_overflow;
   logic        rsp_length_mismatch;
   logic        rsp_trailer_prefix_bad;
   logic        rsp_checksum_mismatch;
   logic [31:0] rsp_expected_sum;

   length_prefixed_string_deframer_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_in_byte            (req_in_byte),
      .req_is_last            (req_is_last),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_result_kind        (rsp_result_kind),
      .rsp_data_byte          (rsp_data_byte),
      .rsp_record_length      (rsp_record_length),
      .rsp_delimiter_error    (rsp_delimiter_error),
      .rsp_length_overflow    (rsp_length_overflow),
      .rsp_length_mismatch    (rsp_length_mismatch),
      .rsp_trailer_prefix_bad (rsp_trailer_prefix_bad),
      .rsp_checksum_mismatch  (rsp_checksum_mismatch),
      .rsp_expected_sum       (rsp_expected_sum)
   );

   // parser state mirrored on the testbench side
   phase_type   ph;
   logic [15:0] hdr_len;
   logic [15:0] pay_left;
   logic [15:0] trl_len;
   logic        flag_delim;
   logic        flag_ovf;
   logic [31:0] sum_prev;
   logic [2:0]  pfx_cnt;
   logic [31:0] sum_val;
   logic        val_done;

   rsp_type     pending_results[$];
   logic [7:0]  strm_q[$];
   int unsigned stream_sum;
   string       noise_chars = "#:@*0123456789sum=";

   bit             gap_on = 1'b1;
   int             burst_left = 0;
   stall_mode_type stall_mode = STALL_PATTERN;
   int             holds_asked = 0;
   int             holds_done = 0;
   int             hold_cnt = 0;
   int             stall_tick = 0;

   int          cycle_cnt = 0;
   int          n_errors = 0;
   int          bytes_sent = 0;
   int          streams_sent = 0;
   int          input_stall_cycles = 0;
   int          kind_seen[4] = '{0, 0, 0, 0};

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic void expect_result(input rsp_type r);
      pending_results = {pending_results, r};
   endfunction

   function automatic void put_char(input logic [7:0] c);
      strm_q = {strm_q, c};
   endfunction

   function automatic void parser_clear();
      ph         = PH_HASH;
      hdr_len    = '0;
      pay_left   = '0;
      trl_len    = '0;
      flag_delim = 1'b0;
      flag_ovf   = 1'b0;
      sum_prev   = '0;
      pfx_cnt    = '0;
      sum_val    = '0;
      val_done   = 1'b0;
   endfunction

   // decimal accumulate that sticks at top
   function automatic logic [31:0] add_digit(input logic [31:0] acc, input logic [3:0] d,
                                             input logic [31:0] top, output logic sat);
      sat = 1'b0;
      if (acc > (top - 32'(d)) / 32'd10) begin
         sat = 1'b1;
         return top;
      end
      return acc * 32'd10 + 32'(d);
   endfunction

   function automatic void deframe_byte(input logic [7:0] b, input logic is_end);
      logic       is_dig;
      logic [3:0] d;
      logic       sat;
      logic       emitted;
      rsp_type    r;
      is_dig  = (b >= CH_ZERO) && (b <= CH_NINE);
      d       = is_dig ? 4'(b - CH_ZERO) : 4'd0;
      emitted = 1'b0;
      r       = '0;
      case (ph)
         PH_HDIG: begin
            if (is_dig) begin
               hdr_len = 16'(add_digit({16'd0, hdr_len}, d, LEN_TOP, sat));
               if (sat) flag_ovf = 1'b1;
            end else begin
               if (b != CH_COLON) flag_delim = 1'b1;
               pay_left = hdr_len;
               ph = (hdr_len != 16'd0) ? PH_PAY : PH_AT;
            end
         end
         PH_PAY: begin
            if (!val_done) begin
               if (pfx_cnt < PREFIX_LEN) begin
                  if (b == SUM_TAG[8 * (3 - pfx_cnt[1:0]) +: 8]) pfx_cnt++;
                  else val_done = 1'b1;
               end else if (is_dig) begin
                  sum_val = add_digit(sum_val, d, SUM_TOP, sat);
               end else begin
                  val_done = 1'b1;
               end
            end
            pay_left--;
            if (pay_left == 16'd0) ph = PH_AT;
            // a payload byte flagged as last is swallowed by the truncation result
            if (!is_end) begin
               r.kind      = KIND_DATA;
               r.data_byte = b;
               expect_result(r);
               emitted = 1'b1;
            end
         end
         PH_AT: begin
            if (b != CH_AT) flag_delim = 1'b1;
            ph = PH_TDIG;
         end
         PH_TDIG: begin
            if (is_dig) begin
               trl_len = 16'(add_digit({16'd0, trl_len}, d, LEN_TOP, sat));
               if (sat) flag_ovf = 1'b1;
            end else begin
               if (b != CH_STAR) flag_delim = 1'b1;
               r.record_length   = hdr_len;
               r.delimiter_error = flag_delim;
               r.length_overflow = flag_ovf;
               r.length_mismatch = (hdr_len != trl_len);
               r.expected_sum    = sum_prev;
               emitted = 1'b1;
               if (is_end) begin
                  r.kind               = KIND_FINAL;
                  r.trailer_prefix_bad = (pfx_cnt < PREFIX_LEN);
                  r.checksum_mismatch  = ((pfx_cnt < PREFIX_LEN) ? 32'd0 : sum_val) != sum_prev;
                  expect_result(r);
                  parser_clear();
               end else begin
                  r.kind = KIND_END;
                  expect_result(r);
                  if ({16'd0, hdr_len} > SUM_TOP - sum_prev) sum_prev = SUM_TOP;
                  else sum_prev = sum_prev + {16'd0, hdr_len};
                  ph = PH_HASH;
               end
            end
         end
         default: begin
            hdr_len    = '0;
            pay_left   = '0;
            trl_len    = '0;
            flag_delim = (b != CH_HASH);
            flag_ovf   = 1'b0;
            pfx_cnt    = '0;
            sum_val    = '0;
            val_done   = 1'b0;
            ph         = PH_HDIG;
         end
      endcase
      if (is_end && !emitted) begin
         r      = '0;
         r.kind = KIND_TRUNC;
         expect_result(r);
         parser_clear();
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      if (n_errors < 40) $display("cycle %0d: mismatch: %s", cycle_cnt, msg);
      n_errors++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         kind_seen[rsp_result_kind]++;
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result of kind %0d with nothing expected",
                                      rsp_result_kind));
         end else begin
            want = pending_results.pop_front();
            check_field("result_kind", 32'(rsp_result_kind), 32'(want.kind));
            check_field("data_byte", 32'(rsp_data_byte), 32'(want.data_byte));
            check_field("record_length", 32'(rsp_record_length),
                        32'(want.record_length));
            check_field("delimiter_error", 32'(rsp_delimiter_error),
                        32'(want.delimiter_error));
            check_field("length_overflow", 32'(rsp_length_overflow),
                        32'(want.length_overflow));
            check_field("length_mismatch", 32'(rsp_length_mismatch),
                        32'(want.length_mismatch));
            check_field("trailer_prefix_bad", 32'(rsp_trailer_prefix_bad),
                        32'(want.trailer_prefix_bad));
            check_field("checksum_mismatch", 32'(rsp_checksum_mismatch),
                        32'(want.checksum_mismatch));
            check_field("expected_sum", rsp_expected_sum, want.expected_sum);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (req_valid && req_stall) input_stall_cycles++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d results outstanding",
                  pending_results.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver back-pressure, with a long hold-off on request
   always @(negedge clock) begin
      if (holds_done != holds_asked) begin
         holds_done = holds_asked;
         hold_cnt   = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
         rsp_stall <= 1'b1;
         hold_cnt--;
      end else begin
         case (stall_mode)
            STALL_RANDOM:  rsp_stall <= ($urandom_range(0, 99) < 35);
            STALL_PATTERN: rsp_stall <= ((stall_tick % 13) < 5);
            default:       rsp_stall <= 1'b0;
         endcase
      end
      stall_tick++;
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_byte(input logic [7:0] b, input logic is_end);
      if (gap_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         burst_left--;
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_is_last <= is_end;
      do @(posedge clock); while (req_stall);
      deframe_byte(b, is_end);
      bytes_sent++;
      @(negedge clock);
   endtask

   // sends the built stream up to stop_at, which carries the last flag
   task automatic send_stream(input int unsigned stop_at);
      for (int unsigned i = 0; i <= stop_at; i++) send_byte(strm_q[i], i == stop_at);
      strm_q.delete();
      streams_sent++;
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endtask

   function automatic string dec_text(input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(0, 7) == 0) s = {"0", s};
      if (v == 0 && $urandom_range(0, 3) == 0) s = "";
      return s;
   endfunction

   // any non-digit other than the expected character
   function automatic logic [7:0] junk_byte(input logic [7:0] avoid);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255));
      while (c == avoid || (c >= CH_ZERO && c <= CH_NINE));
      return c;
   endfunction

   function automatic slot_type pick_bad_slot();
      return ($urandom_range(0, 9) == 0) ? slot_type'($urandom_range(1, 4)) : SLOT_NONE;
   endfunction

   function automatic trl_mode_type pick_trl_mode();
      int unsigned r;
      r = $urandom_range(0, 19);
      if (r == 0) return TRL_OTHER;
      if (r == 1) return TRL_HUGE;
      return TRL_MATCH;
   endfunction

   task automatic put_record(input string pay, input int unsigned n_rand,
                             input trl_mode_type tmode, input slot_type bad);
      int unsigned n;
      int unsigned t;
      n = pay.len() + n_rand;
      case (tmode)
         TRL_OTHER: t = $urandom_range(0, 99);
         TRL_HUGE:  t = 32'hFFFF_FFFF;
         default:   t = n;
      endcase
      put_char(bad == SLOT_HASH ? junk_byte(CH_HASH) : CH_HASH);
      put_text(dec_text(n));
      put_char(bad == SLOT_COLON ? junk_byte(CH_COLON) : CH_COLON);
      put_text(pay);
      repeat (n_rand) put_char(8'($urandom));
      put_char(bad == SLOT_AT ? junk_byte(CH_AT) : CH_AT);
      put_text(dec_text(t));
      put_char(bad == SLOT_STAR ? junk_byte(CH_STAR) : CH_STAR);
      stream_sum += n;
   endtask

   task automatic run_random_stream();
      int unsigned pick;
      int unsigned k;
      string       tpay;
      stream_sum = 0;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         repeat ($urandom_range(1, 30))
            put_char(($urandom_range(0, 1) != 0) ?
                     noise_chars[$urandom_range(0, noise_chars.len() - 1)] :
                     8'($urandom));
         send_stream(strm_q.size() - 1);
         return;
      end
      repeat ($urandom_range(0, 5))
         put_record("", ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) :
                        $urandom_range(0, 8), pick_trl_mode(), pick_bad_slot());
      case ($urandom_range(0, 9))
         5: tpay = $sformatf("sum=%0d", stream_sum + $urandom_range(1, 9));
         6: tpay = $sformatf("sum=%0d;%0d", stream_sum, $urandom_range(0, 99));
         7: tpay = "sum=99999999999";
         8: begin
            tpay = $sformatf("sum=%0d", stream_sum);
            k = $urandom_range(0, 3);
            tpay.putc(k, junk_byte(tpay[k]));
         end
         9: tpay = ($urandom_range(0, 1) != 0) ? "sum=" : "";
         default: tpay = $sformatf("sum=%0d", stream_sum);
      endcase
      put_record(tpay, (tpay.len() == 0) ? $urandom_range(0, 6) : 0,
                 pick_trl_mode(), pick_bad_slot());
      // some streams are cut short anywhere
      if (pick < 20) send_stream($urandom_range(0, strm_q.size() - 1));
      else send_stream(strm_q.size() - 1);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed();
      put_text("#2:");
      put_char(8'h00);
      put_char(8'hff);
      put_text("@2*");
      // every slot wrong, no header digits, lengths differ
      put_text("X;?7!");
      put_text("#5:sum=2@5*");
      send_stream(strm_q.size() - 1);
      put_text("#");
      send_stream(0);
      wait_results_done();
   endtask

   task automatic test_truncation();
      for (int unsigned cut = 0; cut < 8; cut++) begin
         put_text("#3:abc@3*");
         send_stream(cut);
      end
      wait_results_done();
   endtask

   task automatic test_saturation();
      put_text("#70000:xy");
      send_stream(strm_q.size() - 1);
      stream_sum = 0;
      put_record("", 2, TRL_HUGE, SLOT_NONE);
      put_record("sum=99999999999", 0, TRL_MATCH, SLOT_NONE);
      send_stream(strm_q.size() - 1);
      wait_results_done();
   endtask

   task automatic test_random_streams();
      int first;
      first = bytes_sent;
      while (bytes_sent - first < 600) begin
         gap_on     = ($urandom_range(0, 3) != 0);
         stall_mode = stall_mode_type'($urandom_range(0, 2));
         run_random_stream();
         if ($urandom_range(0, 15) == 0) wait_results_done();
      end
      wait_results_done();
   endtask

   task automatic test_backpressure();
      int first;
      gap_on     = 1'b0;
      stall_mode = STALL_NONE;
      first      = bytes_sent;
      holds_asked++;
      while (bytes_sent - first < 120) run_random_stream();
      wait_results_done();
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      req_is_last = 1'b0;
      parser_clear();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_truncation();
      test_saturation();
      test_random_streams();
      test_backpressure();

      repeat (8) @(posedge clock);
      $display("%0d stream bytes in %0d streams gave %0d payload, %0d record end, %0d final",
               bytes_sent, streams_sent, kind_seen[KIND_DATA], kind_seen[KIND_END],
               kind_seen[KIND_FINAL]);
      $display("and %0d truncation results; input held off %0d cycles, %0d mismatches",
               kind_seen[KIND_TRUNC], input_stall_cycles, n_errors);
      if (n_errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
